FILE: rtl/frac_pkg.sv
// Shared constants and controller/datapath interface types for the fraction reducer.
`timescale 1ns / 1ps

package frac_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // Largest magnitude that fits a signed output field
    localparam logic [DATA_WIDTH-1:0] MAX_MAG = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // Operand pair routed into the shared serial divider
    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_NUMER,
        DIV_DENOM
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_step;
        logic     euc_upd;
        logic     save_num;
        logic     save_den;
        logic     out_write;
    } frac_cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic b_zero;
        logic div_last;
        logic out_busy;
    } frac_sts_t;

endpackage

FILE: rtl/frac_dpath.sv
// Datapath: magnitudes, Euclid registers, shared restoring divider and output register.
`timescale 1ns / 1ps

module frac_dpath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [frac_pkg::DATA_WIDTH-1:0] numer_in,
    input  logic signed [frac_pkg::DATA_WIDTH-1:0] denom_in,
    input  frac_pkg::frac_cmd_t                    cmd,
    output frac_pkg::frac_sts_t                    sts,
    output logic signed [frac_pkg::DATA_WIDTH-1:0] numer_out,
    output logic        [frac_pkg::DATA_WIDTH-2:0] denom_out,
    output logic                                   out_valid,
    input  logic                                   out_stall
);
    import frac_pkg::*;

    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] d_mag;
    logic                  sign_in;

    logic [DATA_WIDTH-1:0] a_reg,   a_next;
    logic [DATA_WIDTH-1:0] b_reg,   b_next;
    logic [DATA_WIDTH-1:0] nm_reg,  nm_next;
    logic [DATA_WIDTH-1:0] dm_reg,  dm_next;
    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] numer_out_reg, numer_out_next;
    logic [DATA_WIDTH-2:0] denom_out_reg, denom_out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [DATA_WIDTH:0]   trial;
    logic                  borrow;
    logic [DATA_WIDTH-1:0] nm_sat;
    logic [DATA_WIDTH-1:0] dm_sat;

    assign n_mag   = numer_in[DATA_WIDTH-1] ? (~$unsigned(numer_in) + 1'b1) : $unsigned(numer_in);
    assign d_mag   = denom_in[DATA_WIDTH-1] ? (~$unsigned(denom_in) + 1'b1) : $unsigned(denom_in);
    assign sign_in = (numer_in[DATA_WIDTH-1] ^ denom_in[DATA_WIDTH-1])
                     && (n_mag != '0) && (d_mag != '0);

    // One quotient bit per cycle: shift the next dividend bit into the partial remainder
    assign trial  = {rem_reg, dvd_reg[DATA_WIDTH-1]} - {1'b0, dvs_reg};
    assign borrow = trial[DATA_WIDTH];

    assign nm_sat = (nm_reg > MAX_MAG) ? MAX_MAG : nm_reg;
    assign dm_sat = (dm_reg > MAX_MAG) ? MAX_MAG : dm_reg;

    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        nm_next        = nm_reg;
        dm_next        = dm_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        numer_out_next = numer_out_reg;
        denom_out_next = denom_out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            a_next   = n_mag;
            b_next   = d_mag;
            nm_next  = n_mag;
            dm_next  = d_mag;
            neg_next = sign_in;
        end

        if (cmd.save_num)
        begin
            nm_next = dvd_reg;
        end

        if (cmd.save_den)
        begin
            dm_next = dvd_reg;
        end

        if (cmd.euc_upd)
        begin
            a_next = b_reg;
            b_next = rem_reg;
        end

        if (cmd.div_start)
        begin
            rem_next = '0;
            cnt_next = '0;
            unique case (cmd.div_sel)
                DIV_EUCLID:
                begin
                    dvd_next = a_reg;
                    dvs_next = b_reg;
                end
                DIV_NUMER:
                begin
                    dvd_next = nm_reg;
                    dvs_next = a_reg;
                end
                DIV_DENOM:
                begin
                    dvd_next = dm_reg;
                    dvs_next = a_reg;
                end
                default:
                begin
                    dvd_next = a_reg;
                    dvs_next = b_reg;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_next = borrow ? {rem_reg[DATA_WIDTH-2:0], dvd_reg[DATA_WIDTH-1]}
                              : trial[DATA_WIDTH-1:0];
            dvd_next = {dvd_reg[DATA_WIDTH-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.out_write)
        begin
            numer_out_next = neg_reg ? (~nm_sat + 1'b1) : nm_sat;
            denom_out_next = dm_sat[DATA_WIDTH-2:0];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        nm_reg        <= nm_next;
        dm_reg        <= dm_next;
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        numer_out_reg <= numer_out_next;
        denom_out_reg <= denom_out_next;
    end

    assign sts.mag_zero = (a_reg == '0) || (b_reg == '0);
    assign sts.b_zero   = (b_reg == '0);
    assign sts.div_last = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign sts.out_busy = out_valid_reg && out_stall;

    assign numer_out = $signed(numer_out_reg);
    assign denom_out = denom_out_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/frac_ctrl.sv
// Controller: sequences load, Euclid remainder steps, the two divisions and the result write.
`timescale 1ns / 1ps

module frac_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  frac_pkg::frac_sts_t sts,
    output frac_pkg::frac_cmd_t cmd
);
    import frac_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_E,
        ST_EUPD,
        ST_ETEST,
        ST_DIV_N,
        ST_SAVE_N,
        ST_DIV_D,
        ST_SAVE_D,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DIV_EUCLID;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Zero magnitude: divisor is one, pass magnitudes through
                if (sts.mag_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_EUCLID;
                    state_next    = ST_DIV_E;
                end
            end
            ST_DIV_E:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EUPD;
                end
            end
            ST_EUPD:
            begin
                cmd.euc_upd = 1'b1;
                state_next  = ST_ETEST;
            end
            ST_ETEST:
            begin
                cmd.div_start = 1'b1;
                if (sts.b_zero)
                begin
                    cmd.div_sel = DIV_NUMER;
                    state_next  = ST_DIV_N;
                end
                else
                begin
                    cmd.div_sel = DIV_EUCLID;
                    state_next  = ST_DIV_E;
                end
            end
            ST_DIV_N:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SAVE_N;
                end
            end
            ST_SAVE_N:
            begin
                cmd.save_num  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DENOM;
                state_next    = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SAVE_D;
                end
            end
            ST_SAVE_D:
            begin
                cmd.save_den = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register frees up
                if (!sts.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: rtl/fraction_reducer.sv
// Top level: reduces a signed fraction to lowest terms with Euclid's algorithm.
`timescale 1ns / 1ps

// Takes one item (numer_in, denom_in) at a time and returns numer_out / denom_out in
// lowest terms, sign on the numerator, denominator never negative. Items are handled one
// at a time; one shared restoring divider produces one quotient bit per cycle. With
// either magnitude zero the magnitudes pass straight through to the result. Otherwise the
// block runs Euclid remainder steps (at most 45 for 32-bit operands), each a full
// division followed by an update, then two divisions by the divisor. A finished result
// waits in the output register while the next item is accepted and worked on. A reduced
// magnitude of 2^31 saturates to 2^31-1.
module fraction_reducer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [frac_pkg::DATA_WIDTH-1:0] numer_in,
    input  logic signed [frac_pkg::DATA_WIDTH-1:0] denom_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [frac_pkg::DATA_WIDTH-1:0] numer_out,
    output logic        [frac_pkg::DATA_WIDTH-2:0] denom_out
);
    import frac_pkg::*;

    frac_cmd_t cmd;
    frac_sts_t sts;

    frac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    frac_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .numer_in  (numer_in),
        .denom_in  (denom_in),
        .cmd       (cmd),
        .sts       (sts),
        .numer_out (numer_out),
        .denom_out (denom_out),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
